### src/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared widths, codes, word types and the quarter-wave sine table builder
// for the clip fader.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int FRAME_BITS         = 24;
  localparam int MAX_CHANNELS       = 8;
  localparam int SINE_TABLE_DEPTH   = 1024;
  localparam int GAIN_FRACTION_BITS = 16;

  localparam int SAMPLE_BITS     = 24;
  localparam int GAIN_BITS       = GAIN_FRACTION_BITS + 1;
  localparam int CHAN_BITS       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHAN_COUNT_BITS = 4;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 24;

  localparam int DIVISOR_BITS  = FRAME_BITS + 1;
  localparam int DIVIDEND_BITS = 2 * FRAME_BITS;
  localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);

  localparam int ROM_ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_BITS      = GAIN_FRACTION_BITS + $clog2(SINE_TABLE_DEPTH) + 1;
  localparam int IDX_BITS      = POS_BITS - GAIN_FRACTION_BITS;

  localparam int MUL_BITS  = ((FRAME_BITS > SAMPLE_BITS) ?
                              ((FRAME_BITS > GAIN_BITS) ? FRAME_BITS : GAIN_BITS) :
                              ((SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS)) + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;

  localparam logic [GAIN_BITS-1:0]  UNITY     = {1'b1, {GAIN_FRACTION_BITS{1'b0}}};
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLIP_FRAMES     = 3'd0,
    REG_FADE_IN_FRAMES  = 3'd1,
    REG_FADE_OUT_FRAMES = 3'd2,
    REG_FADE_IN_CURVE   = 3'd3,
    REG_FADE_OUT_CURVE  = 3'd4,
    REG_CHANNEL_COUNT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          clip_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [GAIN_BITS-1:0]          gain_used;
  } out_word_t;

  typedef struct packed {
    logic                     start;
    logic [DIVISOR_BITS-1:0]  rem_init;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [STEP_BITS-1:0]     steps;
    logic [DIVISOR_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [FRAME_BITS-1:0] quotient;
  } div_rsp_t;

  typedef logic [GAIN_BITS-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // sin(k*pi/(2*D)) in q30 by a horner taylor series, rounded to the gain format
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned g;
    longint unsigned one_q30;
    longint unsigned unity_l;
    one_q30 = 64'd1 << 30;
    unity_l = 64'd1 << GAIN_FRACTION_BITS;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      a  = (longint'(k) * 64'd1686629713) / SINE_TABLE_DEPTH;
      a2 = (a * a) >> 30;
      r  = one_q30 - a2 / 110;
      r  = one_q30 - ((a2 * r) >> 30) / 72;
      r  = one_q30 - ((a2 * r) >> 30) / 42;
      r  = one_q30 - ((a2 * r) >> 30) / 20;
      r  = one_q30 - ((a2 * r) >> 30) / 6;
      s  = (a * r) >> 30;
      g  = (s + (64'd1 << (29 - GAIN_FRACTION_BITS))) >> (30 - GAIN_FRACTION_BITS);
      if (g > unity_l) begin
        g = unity_l;
      end
      tab[k] = g[GAIN_BITS-1:0];
    end
    return tab;
  endfunction

endpackage

### src/cdf_divider.sv
// ----------------------------------------------------------------------------
// cdf_divider
// Restoring serial divider, one quotient bit per cycle, with a preset
// partial remainder so a fraction pos/n can start from the numerator.
// ----------------------------------------------------------------------------
module cdf_divider import cdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy;
  logic                     done;
  logic [STEP_BITS-1:0]     count;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVIDEND_BITS-1:0] num;
  logic [FRAME_BITS-1:0]    quo;
  logic [DIVISOR_BITS-1:0]  divisor;

  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    trial;
  logic                     fits;
  logic [DIVISOR_BITS-1:0]  rem_next;

  assign shifted  = {rem, num[DIVIDEND_BITS-1]};
  assign trial    = shifted - {1'b0, divisor};
  assign fits     = shifted >= {1'b0, divisor};
  assign rem_next = fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      num     <= req.dividend;
      quo     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[DIVIDEND_BITS-2:0], 1'b0};
      quo <= {quo[FRAME_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### src/cdf_sine_rom.sv
// ----------------------------------------------------------------------------
// cdf_sine_rom
// Quarter-wave sine table, one registered read port.
// ----------------------------------------------------------------------------
module cdf_sine_rom import cdf_pkg::*; (
  input  logic                     clk,
  input  logic [ROM_ADDR_BITS-1:0] addr,
  output logic [GAIN_BITS-1:0]     data
);

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  always_ff @(posedge clk) begin
    data <= SINE_TAB[addr];
  end

endmodule

### src/clip_dovetail_fader_core.sv
// accept to out_valid: ST_GAIN, ST_SAMPLE_MUL, ST_OUT for channels other than 0
// and for channel 0 outside a fade; channel 0 inside a fade adds ST_DIV, where
// the 16-step divider forms t = i/n; equal power adds ST_RD_LO to ST_INTERP.
// a clip start adds ST_SPLIT, and ST_SPLIT_LOAD with a 48-step split on overlap.
// one word at a time: the input opens again in the same cycle that out_valid rises
// synchronous reset: registers to defaults, unity gain, no fades until a clip start
// ----------------------------------------------------------------------------
// clip_dovetail_fader_core
// Fade-in / fade-out gain for an interleaved clip, one shared divider and
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module clip_dovetail_fader_core import cdf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_word_t                 out_word,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_SPLIT      = 11'b000_0000_0010,
    ST_SPLIT_LOAD = 11'b000_0000_0100,
    ST_GAIN       = 11'b000_0000_1000,
    ST_DIV        = 11'b000_0001_0000,
    ST_RD_LO      = 11'b000_0010_0000,
    ST_RD_HI      = 11'b000_0100_0000,
    ST_INTERP_MUL = 11'b000_1000_0000,
    ST_INTERP     = 11'b001_0000_0000,
    ST_SAMPLE_MUL = 11'b010_0000_0000,
    ST_OUT        = 11'b100_0000_0000
  } state_t;

  localparam logic [POS_BITS-1:0]  POS_PEAK = POS_BITS'(SINE_TABLE_DEPTH) << GAIN_FRACTION_BITS;
  localparam logic [IDX_BITS-1:0]  IDX_LAST = IDX_BITS'(SINE_TABLE_DEPTH);
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRACTION_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] SAT_HIGH =
    $signed({{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});

  state_t state;

  // configuration
  logic [FRAME_BITS-1:0]      clip_frames;
  logic [FRAME_BITS-1:0]      fade_in_frames;
  logic [FRAME_BITS-1:0]      fade_out_frames;
  logic                       fade_in_curve;
  logic                       fade_out_curve;
  logic [CHAN_COUNT_BITS-1:0] channel_count;

  // clip state
  logic [FRAME_BITS-1:0] frame_position;
  logic [CHAN_BITS-1:0]  channel_position;
  logic [FRAME_BITS-1:0] effective_fade_in;
  logic [FRAME_BITS-1:0] effective_fade_out;
  logic [GAIN_BITS-1:0]  frame_gain;

  // working registers
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          fade_is_in;
  logic                          use_curve;
  logic                          div_for_split;
  logic [POS_BITS-1:0]           pos;
  logic [GAIN_BITS-1:0]          s0;
  logic signed [PROD_BITS-1:0]   prod;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic [ROM_ADDR_BITS-1:0] rom_addr;
  logic [GAIN_BITS-1:0]     rom_data;

  logic [CHAN_BITS:0]          chans;
  logic [CHAN_BITS:0]          chan_inc;
  logic [FRAME_BITS-1:0]       fin_c;
  logic [FRAME_BITS-1:0]       fout_c;
  logic [DIVISOR_BITS-1:0]     total;
  logic                        overlap;
  logic                        in_fade_in;
  logic                        in_fade_out;
  logic [DIVISOR_BITS-1:0]     out_end_sum;
  logic [DIVISOR_BITS-1:0]     out_index;
  logic [GAIN_FRACTION_BITS-1:0] t;
  logic [POS_BITS-1:0]         t_pos;
  logic [IDX_BITS-1:0]         idx;
  logic [IDX_BITS-1:0]         idx_lo;
  logic [IDX_BITS-1:0]         idx_hi;
  logic [GAIN_BITS-1:0]        s1;
  logic [GAIN_BITS-1:0]        s_diff;
  logic                        mul_en;
  logic signed [MUL_BITS-1:0]  mul_a;
  logic signed [MUL_BITS-1:0]  mul_b;
  logic [PROD_BITS-1:0]        interp_sum;
  logic signed [PROD_BITS-1:0] rounded;
  logic [SAMPLE_BITS-1:0]      sample_res;
  logic                        out_load;

  cdf_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cdf_sine_rom u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // 0 channels counts as 1, too many as the maximum
  always_comb begin
    if (channel_count == '0) begin
      chans = (CHAN_BITS+1)'(1);
    end else if (32'(channel_count) > 32'(MAX_CHANNELS)) begin
      chans = (CHAN_BITS+1)'(MAX_CHANNELS);
    end else begin
      chans = (CHAN_BITS+1)'(channel_count);
    end
  end
  assign chan_inc = {1'b0, channel_position} + 1'b1;

  // fade split at clip start
  assign fin_c   = (fade_in_frames > clip_frames) ? clip_frames : fade_in_frames;
  assign fout_c  = (fade_out_frames > clip_frames) ? clip_frames : fade_out_frames;
  assign total   = {1'b0, fin_c} + {1'b0, fout_c};
  assign overlap = total > {1'b0, clip_frames};

  // fade region of the current frame
  assign out_end_sum = {1'b0, frame_position} + {1'b0, effective_fade_out};
  assign out_index   = out_end_sum - {1'b0, clip_frames};
  assign in_fade_in  = frame_position < effective_fade_in;
  assign in_fade_out = (frame_position < clip_frames) &&
                       (out_end_sum >= {1'b0, clip_frames}) &&
                       (effective_fade_out != '0);

  assign t     = div_rsp.quotient[GAIN_FRACTION_BITS-1:0];
  assign t_pos = POS_BITS'(t) * POS_BITS'(SINE_TABLE_DEPTH);

  // table position: the end entry holds for the very top of the wave
  assign idx    = pos[POS_BITS-1:GAIN_FRACTION_BITS];
  assign idx_lo = (idx >= IDX_LAST) ? IDX_LAST : idx;
  assign idx_hi = (idx >= IDX_LAST) ? IDX_LAST : idx + 1'b1;
  assign rom_addr = (state == ST_RD_LO) ? ROM_ADDR_BITS'(idx_lo) : ROM_ADDR_BITS'(idx_hi);

  assign s1     = (rom_data < s0) ? s0 : rom_data;
  assign s_diff = s1 - s0;

  always_comb begin
    div_req = '0;
    if (state == ST_GAIN && channel_position == '0 && (in_fade_in || in_fade_out)) begin
      div_req.start    = 1'b1;
      div_req.rem_init = in_fade_in ? {1'b0, frame_position} : out_index;
      div_req.divisor  = in_fade_in ? {1'b0, effective_fade_in} : {1'b0, effective_fade_out};
      div_req.steps    = STEP_BITS'(GAIN_FRACTION_BITS);
    end else if (state == ST_SPLIT_LOAD) begin
      div_req.start    = 1'b1;
      div_req.dividend = prod[DIVIDEND_BITS-1:0];
      div_req.divisor  = total;
      div_req.steps    = STEP_BITS'(DIVIDEND_BITS);
    end
  end

  // shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = $signed({{(MUL_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample});
    mul_b  = $signed({{(MUL_BITS-GAIN_BITS){1'b0}}, frame_gain});
    case (state)
      ST_SPLIT: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_BITS-FRAME_BITS){1'b0}}, fin_c});
        mul_b  = $signed({{(MUL_BITS-FRAME_BITS){1'b0}}, clip_frames});
      end
      ST_INTERP_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_BITS-GAIN_BITS){1'b0}}, s_diff});
        mul_b  = $signed({{(MUL_BITS-GAIN_FRACTION_BITS){1'b0}},
                          pos[GAIN_FRACTION_BITS-1:0]});
      end
      ST_SAMPLE_MUL: begin
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign interp_sum = $unsigned(prod) + ROUND_HALF;
  assign rounded    = (prod + $signed(ROUND_HALF)) >>> GAIN_FRACTION_BITS;
  assign sample_res = (rounded > SAT_HIGH) ? SAT_HIGH[SAMPLE_BITS-1:0]
                                           : rounded[SAMPLE_BITS-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_frames     <= FRAME_BITS'(1);
      fade_in_frames  <= '0;
      fade_out_frames <= '0;
      fade_in_curve   <= 1'b0;
      fade_out_curve  <= 1'b0;
      channel_count   <= CHAN_COUNT_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLIP_FRAMES:     clip_frames     <= FRAME_BITS'(cfg_data);
        REG_FADE_IN_FRAMES:  fade_in_frames  <= FRAME_BITS'(cfg_data);
        REG_FADE_OUT_FRAMES: fade_out_frames <= FRAME_BITS'(cfg_data);
        REG_FADE_IN_CURVE:   fade_in_curve   <= cfg_data[0];
        REG_FADE_OUT_CURVE:  fade_out_curve  <= cfg_data[0];
        REG_CHANNEL_COUNT:   channel_count   <= cfg_data[CHAN_COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and clip state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      frame_position     <= '0;
      channel_position   <= '0;
      effective_fade_in  <= '0;
      effective_fade_out <= '0;
      frame_gain         <= UNITY;
      out_valid          <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_word.clip_start) begin
              frame_position   <= '0;
              channel_position <= '0;
              state            <= ST_SPLIT;
            end else begin
              if ({1'b0, channel_position} >= chans) begin
                channel_position <= '0;
              end
              state <= ST_GAIN;
            end
          end
        end
        ST_SPLIT: begin
          if (overlap) begin
            state <= ST_SPLIT_LOAD;
          end else begin
            effective_fade_in  <= fin_c;
            effective_fade_out <= fout_c;
            state              <= ST_GAIN;
          end
        end
        ST_SPLIT_LOAD: begin
          state <= ST_DIV;
        end
        ST_GAIN: begin
          if (channel_position != '0) begin
            state <= ST_SAMPLE_MUL;
          end else if (in_fade_in || in_fade_out) begin
            state <= ST_DIV;
          end else begin
            frame_gain <= UNITY;
            state      <= ST_SAMPLE_MUL;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (div_for_split) begin
              effective_fade_in  <= div_rsp.quotient;
              effective_fade_out <= clip_frames - div_rsp.quotient;
              state              <= ST_GAIN;
            end else if (use_curve) begin
              state <= ST_RD_LO;
            end else begin
              frame_gain <= fade_is_in ? {1'b0, t} : UNITY - {1'b0, t};
              state      <= ST_SAMPLE_MUL;
            end
          end
        end
        ST_RD_LO: begin
          state <= ST_RD_HI;
        end
        ST_RD_HI: begin
          state <= ST_INTERP_MUL;
        end
        ST_INTERP_MUL: begin
          state <= ST_INTERP;
        end
        ST_INTERP: begin
          frame_gain <= s0 + interp_sum[GAIN_FRACTION_BITS +: GAIN_BITS];
          state      <= ST_SAMPLE_MUL;
        end
        ST_SAMPLE_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            if (chan_inc >= chans) begin
              channel_position <= '0;
              if (frame_position != FRAME_MAX) begin
                frame_position <= frame_position + 1'b1;
              end
            end else begin
              channel_position <= chan_inc[CHAN_BITS-1:0];
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sample <= in_word.sample_in;
    end
    if (state == ST_SPLIT) begin
      div_for_split <= 1'b1;
    end else if (state == ST_GAIN) begin
      div_for_split <= 1'b0;
      fade_is_in    <= in_fade_in;
      use_curve     <= in_fade_in ? fade_in_curve : fade_out_curve;
    end
    if (state == ST_DIV && div_rsp.done) begin
      pos <= fade_is_in ? t_pos : POS_PEAK - t_pos;
    end
    if (state == ST_RD_HI) begin
      s0 <= rom_data;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (out_load) begin
      out_word.sample_out <= $signed(sample_res);
      out_word.gain_used  <= frame_gain;
    end
  end

endmodule

### src/cdf_checker.sv
// ----------------------------------------------------------------------------
// cdf_checker
// Port-level checks on the clip fader, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cdf_checker import cdf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // one word at a time: an accepted word keeps the input closed next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // a gain never goes above unity
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.gain_used <= UNITY))
    else $error("gain above unity");

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word changed");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind clip_dovetail_fader_core cdf_checker u_cdf_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Clip fader testbench: drives interleaved clips through the core under
// varied fade settings and idle mixes, predicts every output word from its
// own gain model and checks it field by field.
// ----------------------------------------------------------------------------
module tb;
  import cdf_pkg::*;

  // gain model of the fader plus the queue of words still owed by the core
  class fade_tracker;
    logic [GAIN_BITS-1:0] sine_q16 [0:SINE_TABLE_DEPTH];
    bit [FRAME_BITS-1:0]  clip_len;
    bit [FRAME_BITS-1:0]  in_req;
    bit [FRAME_BITS-1:0]  out_req;
    bit                   in_sine;
    bit                   out_sine;
    bit [3:0]             chan_reg;
    bit [FRAME_BITS-1:0]  frame_idx;
    bit [FRAME_BITS-1:0]  fade_in_len;
    bit [FRAME_BITS-1:0]  fade_out_len;
    int unsigned          chan_idx;
    bit [GAIN_BITS-1:0]   frame_gain;
    out_word_t            faded_q [$];
    int unsigned          errors;
    int unsigned          matched;
    int unsigned          samples;
    int unsigned          clip_starts;

    function new();
      longint unsigned a;
      longint unsigned a2;
      longint unsigned r;
      longint unsigned s;
      longint unsigned g;
      longint unsigned divs [5];
      divs = '{110, 72, 42, 20, 6};
      // quarter-wave sine in q30, taylor terms folded from the top down
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
        a  = k;
        a  = (a * 64'd1686629713) / SINE_TABLE_DEPTH;
        a2 = (a * a) >> 30;
        r  = 64'd1 << 30;
        foreach (divs[j]) r = (64'd1 << 30) - (((a2 * r) >> 30) / divs[j]);
        s  = (a * r) >> 30;
        g  = (s + (64'd1 << (29 - GAIN_FRACTION_BITS))) >> (30 - GAIN_FRACTION_BITS);
        sine_q16[k] = (g > UNITY) ? UNITY : g[GAIN_BITS-1:0];
      end
      clip_len     = 1;
      in_req       = 0;
      out_req      = 0;
      in_sine      = 0;
      out_sine     = 0;
      chan_reg     = 1;
      frame_idx    = 0;
      chan_idx     = 0;
      fade_in_len  = 0;
      fade_out_len = 0;
      frame_gain   = UNITY;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        REG_CLIP_FRAMES:     clip_len = v;
        REG_FADE_IN_FRAMES:  in_req = v;
        REG_FADE_OUT_FRAMES: out_req = v;
        REG_FADE_IN_CURVE:   in_sine = v[0];
        REG_FADE_OUT_CURVE:  out_sine = v[0];
        REG_CHANNEL_COUNT:   chan_reg = v[3:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sine_lookup(longint unsigned p);
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned s0;
      longint unsigned s1;
      idx  = p >> GAIN_FRACTION_BITS;
      frac = p & ((64'd1 << GAIN_FRACTION_BITS) - 1);
      if (idx >= SINE_TABLE_DEPTH) return sine_q16[SINE_TABLE_DEPTH];
      s0 = sine_q16[idx];
      s1 = sine_q16[idx + 1];
      if (s1 < s0) s1 = s0;
      return s0 + (((s1 - s0) * frac + (64'd1 << (GAIN_FRACTION_BITS - 1)))
                   >> GAIN_FRACTION_BITS);
    endfunction

    function longint unsigned frame_gain_for(longint unsigned pos);
      longint unsigned t;
      longint unsigned i;
      if (pos < fade_in_len) begin
        t = (pos << GAIN_FRACTION_BITS) / fade_in_len;
        return in_sine ? sine_lookup(t * SINE_TABLE_DEPTH) : t;
      end
      // fade-out end tracks the live clip length
      if (pos < clip_len && pos + fade_out_len >= clip_len && fade_out_len != 0) begin
        i = pos + fade_out_len - clip_len;
        t = (i << GAIN_FRACTION_BITS) / fade_out_len;
        if (out_sine)
          return sine_lookup((longint'(SINE_TABLE_DEPTH) << GAIN_FRACTION_BITS) -
                             t * SINE_TABLE_DEPTH);
        return UNITY - t;
      end
      return UNITY;
    endfunction

    function void split_fades();
      longint unsigned fin;
      longint unsigned fout;
      longint unsigned total;
      fin  = (in_req > clip_len) ? clip_len : in_req;
      fout = (out_req > clip_len) ? clip_len : out_req;
      total = fin + fout;
      if (total > clip_len) begin
        fin  = (fin * clip_len) / total;
        fout = clip_len - fin;
      end
      fade_in_len  = FRAME_BITS'(fin);
      fade_out_len = FRAME_BITS'(fout);
    endfunction

    function void accept_sample(in_word_t w);
      longint      s;
      longint      acc;
      int unsigned chans;
      out_word_t   want;
      samples++;
      if (w.clip_start) begin
        clip_starts++;
        frame_idx = 0;
        chan_idx  = 0;
        split_fades();
      end
      chans = (chan_reg == 0) ? 1 : ((chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg);
      if (chan_idx >= chans) chan_idx = 0;
      if (chan_idx == 0) frame_gain = GAIN_BITS'(frame_gain_for(frame_idx));
      s   = $signed(w.sample_in);
      acc = s * longint'(frame_gain);
      // offset to unsigned, round half up, saturate, remove offset
      acc = acc + (longint'(1) << (23 + GAIN_FRACTION_BITS)) +
            (longint'(1) << (GAIN_FRACTION_BITS - 1));
      acc = acc >>> GAIN_FRACTION_BITS;
      if (acc > 'hFFFFFF) acc = 'hFFFFFF;
      want.sample_out = acc[23:0] + 24'h800000;
      want.gain_used  = frame_gain;
      faded_q.push_back(want);
      chan_idx++;
      if (chan_idx >= chans) begin
        chan_idx = 0;
        if (frame_idx < FRAME_MAX) frame_idx++;
      end
    endfunction

    function void compare_output(out_word_t got);
      out_word_t want;
      if (faded_q.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: output word with nothing expected: sample %0d gain %0d",
                   $time, got.sample_out, got.gain_used);
        return;
      end
      want = faded_q.pop_front();
      matched++;
      if (got.sample_out !== want.sample_out) begin
        errors++;
        if (errors <= 20)
          $display("%0t: sample_out expected %0d got %0d",
                   $time, want.sample_out, got.sample_out);
      end
      if (got.gain_used !== want.gain_used) begin
        errors++;
        if (errors <= 20)
          $display("%0t: gain_used expected %0d got %0d",
                   $time, want.gain_used, got.gain_used);
      end
    endfunction

    function int unsigned pending();
      return faded_q.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_word_t                  in_word = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_word_t                 out_word;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req = 0;

  fade_tracker board = new();

  clip_dovetail_fader_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs counted here
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.compare_output(out_word);
  end

  initial begin
    #(15_000_000);
    $display("%0t: timed out with %0d words outstanding", $time, board.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic start);
    in_word_t w;
    w.sample_in  = smp;
    w.clip_start = start;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    board.accept_sample(w);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    board.write_reg(idx, v);
  endtask

  task automatic program_fader(logic [CFG_DATA_BITS-1:0] clip, logic [CFG_DATA_BITS-1:0] fin,
                               logic [CFG_DATA_BITS-1:0] fout, logic in_c, logic out_c,
                               logic [3:0] chans);
    put_reg(REG_CLIP_FRAMES, clip);
    put_reg(REG_FADE_IN_FRAMES, fin);
    put_reg(REG_FADE_OUT_FRAMES, fout);
    put_reg(REG_FADE_IN_CURVE, CFG_DATA_BITS'(in_c));
    put_reg(REG_FADE_OUT_CURVE, CFG_DATA_BITS'(out_c));
    put_reg(REG_CHANNEL_COUNT, CFG_DATA_BITS'(chans));
    cfg_write <= 1'b0;
  endtask

  // clips with random content; a few stray clip starts and cut-short clips
  task automatic run_phase(int unsigned target, bit do_hold, bit do_pause);
    int unsigned sent;
    int unsigned frames;
    int unsigned chans;
    logic        start;
    sent = 0;
    while (sent < target) begin
      chans = (board.chan_reg == 0) ? 1 :
              ((board.chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : board.chan_reg);
      frames = (board.clip_len <= 40) ? board.clip_len + $urandom_range(0, 3) :
                                        $urandom_range(1, 6);
      if ($urandom_range(9) == 0) frames = $urandom_range(1, frames);
      for (int f = 0; f < frames && sent < target; f++) begin
        for (int c = 0; c < chans && sent < target; c++) begin
          start = (f == 0 && c == 0) ? ($urandom_range(19) != 0) : ($urandom_range(99) < 2);
          send_sample(SAMPLE_BITS'($urandom), start);
          sent++;
          if (do_hold && sent == target / 3) hold_req = 300 + $urandom_range(200);
          if (do_pause && sent == 2 * target / 3) begin
            wait_drained();
            if ($urandom_range(1) == 1) begin
              put_reg(REG_CLIP_FRAMES, CFG_DATA_BITS'($urandom_range(1, 20)));
              cfg_write <= 1'b0;
            end
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0]   edge_smp [5];
    logic [CFG_DATA_BITS-1:0] clip;
    logic [CFG_DATA_BITS-1:0] fin;
    logic [CFG_DATA_BITS-1:0] fout;
    logic [3:0]               ch;
    bit                       ok;
    edge_smp = '{24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h800000, 24'h000001};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no clip start yet: unity gain
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    wait_drained();

    // overlapping fades get split, sine in, linear out, channel count 0
    program_fader(6, 4, 4, 1'b1, 1'b0, 4'd0);
    for (int f = 0; f < 8; f++)
      send_sample((f < 5) ? edge_smp[f] : SAMPLE_BITS'($urandom), f == 0);
    wait_drained();

    // clip shortened mid clip: fade-in wins on the shared frame, then cosine out
    program_fader(6, 2, 3, 1'b0, 1'b1, 4'd2);
    send_sample(edge_smp[0], 1'b1);
    send_sample(edge_smp[3], 1'b0);
    wait_drained();
    put_reg(REG_CLIP_FRAMES, 3);
    cfg_write <= 1'b0;
    for (int k = 0; k < 4; k++) send_sample(edge_smp[k], 1'b0);
    wait_drained();

    // largest lengths, both equal power, channel count above the maximum
    program_fader(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 4'd15);
    for (int k = 0; k < 9; k++)
      send_sample((k < 5) ? edge_smp[k] : SAMPLE_BITS'($urandom), k == 0);

    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      if ($urandom_range(7) == 0) begin
        clip = CFG_DATA_BITS'($urandom_range(1, 24'hFFFFFF));
        fin  = CFG_DATA_BITS'($urandom);
        fout = CFG_DATA_BITS'($urandom);
      end else begin
        clip = CFG_DATA_BITS'($urandom_range(1, 20));
        fin  = CFG_DATA_BITS'($urandom_range(0, clip + 4));
        fout = CFG_DATA_BITS'($urandom_range(0, clip + 4));
      end
      if (ph == 0) clip = 1;
      if (ph == 11) begin
        clip = 24'hFFFFFF;
        fin  = 0;
        fout = 24'hFFFFFF;
      end
      ch = ($urandom_range(4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      program_fader(clip, fin, fout, 1'($urandom), 1'($urandom), ch);
      run_phase(108, ph == 0 || $urandom_range(2) == 0, ph == 1 || $urandom_range(2) == 0);
    end

    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d samples over %0d clip starts, %0d output words compared",
             board.samples, board.clip_starts, board.matched);
    $display("linear and equal-power fades, overlap splits, mid-clip length changes, stalls");
    ok = (board.errors == 0) && (board.pending() == 0);
    if (board.pending() != 0)
      $display("%0d expected words never arrived", board.pending());
    if (ok) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/cdf_pkg.sv
src/cdf_divider.sv
src/cdf_sine_rom.sv
src/clip_dovetail_fader_core.sv
src/cdf_checker.sv
test/tb.sv
